// ===== src/cfs_pkg.sv =====
// shared constants and types for the small cholesky factor block
package cfs_pkg;

  localparam int MAX_SIZE    = 3;
  localparam int FRAC_BITS   = 16;
  localparam int STORE_DEPTH = (MAX_SIZE * (MAX_SIZE + 1)) / 2;
  localparam int IDX_W       = $clog2(MAX_SIZE);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  typedef struct packed {
    logic               start;
    logic [1:0]         op;
    logic signed [63:0] opa;
    logic signed [31:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } alu_rsp_t;

endpackage

// ===== src/cfs_alu.sv =====
// shared iterative unit: q multiply, bitwise square root and restoring divide
module cfs_alu
  import cfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_SQRT = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_FIN  = 3'd4;

  localparam logic signed [63:0] POS_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] NEG_MAX = -64'sh0000_0000_8000_0000;

  logic [2:0]         state;
  logic [5:0]         cnt;
  logic               neg;
  logic               is_div;
  logic [63:0]        prod;
  logic [63:0]        rad;
  logic [34:0]        rem;
  logic [63:0]        quo;
  logic [31:0]        den;
  logic               done;
  logic signed [63:0] value;

  logic [31:0] mag_x, mag_y;
  logic [63:0] mag_a;
  logic [34:0] srem_sh, trial;
  logic [34:0] drem_sh;
  logic [63:0] prod_sh;

  assign mag_x   = req.opa[31] ? (~req.opa[31:0] + 32'd1) : req.opa[31:0];
  assign mag_y   = req.opb[31] ? (~req.opb + 32'd1) : req.opb;
  assign mag_a   = req.opa[63] ? (~req.opa + 64'd1) : req.opa;
  assign srem_sh = {rem[32:0], rad[63:62]};
  assign trial   = {1'b0, quo[31:0], 2'b01};
  assign drem_sh = {rem[33:0], rad[63]};
  assign prod_sh = prod >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              OP_MUL: begin
                prod  <= 64'(mag_x) * 64'(mag_y);
                neg   <= req.opa[31] ^ req.opb[31];
                state <= A_MUL;
              end
              OP_SQRT: begin
                rad    <= req.opa << FRAC_BITS;
                rem    <= '0;
                quo    <= '0;
                cnt    <= 6'd31;
                is_div <= 1'b0;
                state  <= A_SQRT;
              end
              default: begin
                rad    <= mag_a << FRAC_BITS;
                rem    <= '0;
                quo    <= '0;
                den    <= req.opb;
                neg    <= req.opa[63];
                cnt    <= 6'd63;
                is_div <= 1'b1;
                state  <= A_DIV;
              end
            endcase
          end
        end
        A_MUL: begin
          value <= neg ? -$signed(prod_sh) : $signed(prod_sh);
          done  <= 1'b1;
          state <= A_IDLE;
        end
        A_SQRT: begin
          // two radicand bits per step, one root bit out
          if (srem_sh >= trial) begin
            rem <= srem_sh - trial;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= srem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= A_FIN;
        end
        A_DIV: begin
          if (drem_sh >= {3'b000, den}) begin
            rem <= drem_sh - {3'b000, den};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= drem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          rad <= rad << 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= A_FIN;
        end
        A_FIN: begin
          if (!is_div) begin
            value <= quo[31] ? POS_MAX : $signed({32'd0, quo[31:0]});
          end else if (|quo[63:31]) begin
            value <= neg ? NEG_MAX : POS_MAX;
          end else begin
            value <= neg ? -$signed(quo) : $signed(quo);
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

// ===== src/cholesky_factor_small.sv =====
// top level: loads the upper triangle, sequences the factor steps, emits results
//
// usage: write matrix_size on the cfg channel (cfg_valid/cfg_ready/cfg_data); cfg_ready
// is high only in the load phase, where a cfg word wins over an entry in the same cycle.
// 0 or 1 acts as two, and a write discards any partial load. Then send the upper
// triangle entries, row-major, on in_valid/in_ready/entry_value, one word a cycle while
// in_ready is high. After the last entry in_ready drops and one shared unit works
// through the factor: each entry takes a multiply per earlier row, then a square root
// on the diagonal or a divide elsewhere, one request at a time. Results come out on
// out_valid/out_ready, one word per accepted transfer, in row-major order of R with
// row, col and last; a non-positive pivot gives a single word with failed and last
// set. A stalled receiver simply holds the block in the emit phase; loading resumes
// once the last word is taken. Reset (rst, synchronous) sets the size to three and
// empties the load.
module cholesky_factor_small
  import cfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] factor_value,
  output logic [1:0]         row,
  output logic [1:0]         col,
  output logic               failed,
  output logic               last
);

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_CHK      = 3'd2;
  localparam logic [2:0] S_MUL_WAIT = 3'd3;
  localparam logic [2:0] S_OP_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0]             state;
  logic [1:0]             msize;
  logic [CNT_W-1:0]       load_count;
  logic signed [31:0]     store [STORE_DEPTH];
  logic signed [31:0]     r [MAX_SIZE][MAX_SIZE];
  logic [IDX_W-1:0]       ci, cj, ck, oi, oj;
  logic [CNT_W-1:0]       t;
  logic signed [63:0]     sum;
  logic                   fail;

  logic [IDX_W-1:0] nm1;
  logic [CNT_W-1:0] need;
  logic             do_mul, pivot_bad;
  alu_req_t         req;
  alu_rsp_t         rsp;

  always_comb begin
    logic [2:0] n;
    n = {1'b0, msize};
    if (n < 3'd2) n = 3'd2;
    if (n > 3'(MAX_SIZE)) n = 3'(MAX_SIZE);
    nm1  = IDX_W'(n - 3'd1);
    need = CNT_W'(({1'b0, n} * ({1'b0, n} + 4'd1)) >> 1);
  end

  assign do_mul    = ck < ci;
  assign pivot_bad = (ci == cj) && (sum <= 64'sd0);

  always_comb begin
    req.start = (state == S_CHK) && (do_mul || !pivot_bad);
    if (do_mul) begin
      req.op  = OP_MUL;
      req.opa = 64'(r[ck][ci]);
      req.opb = r[ck][cj];
    end else begin
      req.op  = (ci == cj) ? OP_SQRT : OP_DIV;
      req.opa = sum;
      req.opb = r[ci][ci];
    end
  end

  cfs_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign cfg_ready    = (state == S_LOAD);
  assign in_ready     = (state == S_LOAD) && !cfg_valid;
  assign out_valid    = (state == S_EMIT);
  assign factor_value = fail ? 32'sd0 : r[oi][oj];
  assign row          = 2'(oi);
  assign col          = 2'(oj);
  assign failed       = fail;
  assign last         = fail || ((oi == nm1) && (oj == nm1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      msize      <= 2'd3;
      load_count <= '0;
      fail       <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (cfg_valid) begin
            msize      <= cfg_data;
            load_count <= '0;
          end else if (in_valid) begin
            store[load_count] <= entry_value;
            if (load_count == need - CNT_W'(1)) begin
              load_count <= '0;
              ci         <= '0;
              cj         <= '0;
              t          <= '0;
              state      <= S_READ;
            end else begin
              load_count <= load_count + CNT_W'(1);
            end
          end
        end
        S_READ: begin
          sum   <= 64'(store[t]);
          ck    <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (do_mul) begin
            state <= S_MUL_WAIT;
          end else if (pivot_bad) begin
            fail  <= 1'b1;
            oi    <= ci;
            oj    <= ci;
            state <= S_EMIT;
          end else begin
            state <= S_OP_WAIT;
          end
        end
        S_MUL_WAIT: begin
          if (rsp.done) begin
            sum   <= sum - rsp.value;
            ck    <= ck + IDX_W'(1);
            state <= S_CHK;
          end
        end
        S_OP_WAIT: begin
          if (rsp.done) begin
            r[ci][cj] <= rsp.value[31:0];
            t         <= t + CNT_W'(1);
            state     <= S_READ;
            if (cj == nm1) begin
              if (ci == nm1) begin
                fail  <= 1'b0;
                oi    <= '0;
                oj    <= '0;
                state <= S_EMIT;
              end else begin
                ci <= ci + IDX_W'(1);
                cj <= ci + IDX_W'(1);
              end
            end else begin
              cj <= cj + IDX_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (last) begin
              state <= S_LOAD;
            end else if (oj == nm1) begin
              oi <= oi + IDX_W'(1);
              oj <= oi + IDX_W'(1);
            end else begin
              oj <= oj + IDX_W'(1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // no loading while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted while results pending");

  // a failed word is always the final one and carries a zero value
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
      (out_valid && failed) |-> (last && factor_value == 32'sd0 && row == col))
    else $error("failed word malformed");

  // only the upper triangle is emitted
  a_upper: assert property (@(posedge clk) disable iff (rst) out_valid |-> (col >= row))
    else $error("lower triangle entry emitted");

  // the unit answers only while a step waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
      rsp.done |-> (state == S_MUL_WAIT || state == S_OP_WAIT))
    else $error("unit result with no step waiting");

endmodule

// ===== tb/cfs_checker.sv =====
// watches the channels of the small cholesky factor block and checks every result word
`timescale 1ns / 1ps

module cfs_checker
  import cfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] entry_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] factor_value,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic               failed,
  input  logic               last,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         row;
    logic [1:0]         col;
    logic               failed;
    logic               last;
  } factor_word_t;

  factor_word_t      factor_q[$];
  longint            entries[STORE_DEPTH];
  int                order;
  int                loaded;

  assign pending = factor_q.size();

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic bit [63:0] mag(longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  // product of two q16.16 values, truncated toward zero
  function automatic longint qmul(longint x, longint y);
    bit [63:0] m;
    m = (mag(x) * mag(y)) >> FRAC_BITS;
    return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic bit [63:0] int_root(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // (num << frac) / den, truncated toward zero, saturated
  function automatic longint qdiv(longint num, longint den);
    bit [63:0] m;
    bit [63:0] d;
    bit [63:0] hi;
    bit [63:0] rem;
    bit [63:0] q;
    m = mag(num);
    d = 64'(den);
    if (d == 0) return 0;
    hi = m / d;
    rem = m % d;
    if (hi >= (64'd1 << (32 - FRAC_BITS))) begin
      q = 64'd1 << 32;
    end else begin
      q = hi << FRAC_BITS;
      for (int b = FRAC_BITS - 1; b >= 0; b--) begin
        rem = rem << 1;
        if (rem >= d) begin
          rem = rem - d;
          q[b] = 1'b1;
        end
      end
    end
    return sat32(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  task automatic factorise(int n);
    longint       r[MAX_SIZE][MAX_SIZE];
    longint       sum;
    factor_word_t w;
    int           t;
    int           cnt;
    int           need;
    t = 0;
    cnt = 0;
    need = n * (n + 1) / 2;
    for (int i = 0; i < MAX_SIZE; i++)
      for (int j = 0; j < MAX_SIZE; j++) r[i][j] = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        sum = entries[t];
        t++;
        for (int k = 0; k < i; k++) sum -= qmul(r[k][i], r[k][j]);
        if (i == j) begin
          if (sum <= 0) begin
            w.value = 0;
            w.row = 2'(i);
            w.col = 2'(i);
            w.failed = 1'b1;
            w.last = 1'b1;
            factor_q.push_back(w);
            return;
          end
          r[i][i] = sat32(longint'(int_root(64'(sum) << FRAC_BITS)));
        end else begin
          r[i][j] = qdiv(sum, r[i][i]);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        w.value = 32'(r[i][j]);
        w.row = 2'(i);
        w.col = 2'(j);
        w.failed = 1'b0;
        cnt++;
        w.last = (cnt == need);
        factor_q.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    factor_word_t w;
    int           need;
    if (rst) begin
      factor_q.delete();
      order <= 3;
      loaded <= 0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order <= (cfg_data < 2) ? 2 : ((cfg_data > MAX_SIZE) ? MAX_SIZE : int'(cfg_data));
        loaded <= 0;
      end
      if (in_valid && in_ready) begin
        need = order * (order + 1) / 2;
        entries[loaded] = entry_value;
        if (loaded + 1 >= need) begin
          factorise(order);
          loaded <= 0;
        end else begin
          loaded <= loaded + 1;
        end
      end
      if (out_valid && out_ready) begin
        if (factor_q.size() == 0) begin
          $error("result word with nothing expected: row %0d col %0d", row, col);
          errors <= errors + 1;
        end else begin
          w = factor_q.pop_front();
          if (factor_value !== w.value || row !== w.row || col !== w.col ||
              failed !== w.failed || last !== w.last)
            errors <= errors + 1;
          if (factor_value !== w.value)
            $error("factor_value expected %0d got %0d", w.value, factor_value);
          if (row !== w.row) $error("row expected %0d got %0d", w.row, row);
          if (col !== w.col) $error("col expected %0d got %0d", w.col, col);
          if (failed !== w.failed)
            $error("failed expected %0d got %0d", w.failed, failed);
          if (last !== w.last) $error("last expected %0d got %0d", w.last, last);
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// stimulus and verdict for the small cholesky factor block
`timescale 1ns / 1ps

module tb;
  import cfs_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 600;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] entry_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] factor_value;
  logic [1:0]         row;
  logic [1:0]         col;
  logic               failed;
  logic               last;
  int                 errors;
  int                 pending;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  int                 quiet_cycles = 0;
  int                 order = 3;
  int                 sent = 0;

  always #5 clk = ~clk;

  cholesky_factor_small u_dut (.*);

  cfs_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog on cycles where no channel moves a word
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic set_size(logic [1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    order <= (v < 2) ? 2 : int'(v);
    @(posedge clk);
  endtask

  task automatic send_word(logic signed [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    entry_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] spread(int lim);
    return $signed($urandom_range(2 * lim)) - lim;
  endfunction

  // mostly positive definite by diagonal dominance, some wild matrices
  task automatic send_matrix();
    int kind;
    int dlim;
    kind = $urandom_range(99);
    dlim = ($urandom_range(3) == 0) ? 32'h7fff_ffff : (1 << $urandom_range(10, 26));
    for (int i = 0; i < order; i++) begin
      for (int j = i; j < order; j++) begin
        if (kind < 15) send_word($urandom);
        else if (kind < 25) send_word(spread(1 << 17));
        else if (i == j) send_word($urandom_range(dlim, dlim / 2));
        else if (kind < 35) send_word(spread(32'h7fff_ffff));
        else send_word(spread(dlim / 4));
      end
    end
  endtask

  initial begin
    logic [1:0] sizes[6];
    sizes = '{2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_size(2'd3);

    // identity
    send_word(32'sh0001_0000); send_word(0); send_word(0);
    send_word(32'sh0001_0000); send_word(0); send_word(32'sh0001_0000);
    // every entry at the positive extreme
    repeat (6) send_word(32'sh7fff_ffff);
    // most negative first pivot fails at once
    send_word(32'sh8000_0000);
    repeat (5) send_word(32'sh8000_0000);
    // second pivot sum exactly zero
    send_word(32'sh0001_0000); send_word(32'sh0001_0000); send_word(0);
    send_word(32'sh0001_0000); send_word(0); send_word(32'sh0001_0000);
    settle();

    for (int p = 0; p < 6; p++) begin
      set_size(sizes[p]);
      while (sent < 24 + (p + 1) * 78) begin
        if (sent < 184) begin
          send_idle = 6;
          recv_idle = 74;
        end else if (sent < 344) begin
          send_idle = 74;
          recv_idle = 6;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        send_matrix();
      end
      settle();
    end

    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ===== cholesky_factor_small.f =====
src/cfs_pkg.sv
src/cfs_alu.sv
src/cholesky_factor_small.sv
tb/cfs_checker.sv
tb/tb.sv
